FILE: design/bprq_pkg.sv
// Shared constants, codes and helper functions for the bitmap priority ready queue.
`default_nettype none

package bprq_pkg;

	// Sizing
	localparam int NUM_PRIORITIES = 32;
	localparam int NUM_TASKS      = 16;
	localparam int ROW_W          = 8;
	localparam int ROW_SHIFT      = 3;
	localparam logic [ROW_SHIFT-1:0] ROW_MASK = 3'h7;
	localparam int NUM_ROWS       = (NUM_PRIORITIES + ROW_W - 1) / ROW_W;
	localparam int ROW_IDX_W      = $clog2(NUM_ROWS);
	localparam int PRIO_W         = $clog2(NUM_PRIORITIES);
	localparam int TASK_W         = $clog2(NUM_TASKS);
	localparam int STEP_W         = $clog2(NUM_TASKS + 1);

	// Transaction field widths
	localparam int OP_W       = 1;
	localparam int TASK_ID_W  = 4;
	localparam int PRIO_REQ_W = 5;
	localparam int STATUS_W   = 2;

	// Operation codes
	localparam logic [OP_W-1:0] OP_INSERT = 1'b0;
	localparam logic [OP_W-1:0] OP_REMOVE = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_DUP    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd2;

	// Controller to datapath command codes
	localparam int CMD_W = 4;
	localparam logic [CMD_W-1:0] CMD_NOP        = 4'd0;
	localparam logic [CMD_W-1:0] CMD_CAPTURE    = 4'd1;
	localparam logic [CMD_W-1:0] CMD_REJECT_DUP = 4'd2;
	localparam logic [CMD_W-1:0] CMD_REJECT_ABS = 4'd3;
	localparam logic [CMD_W-1:0] CMD_INS_READ   = 4'd4;
	localparam logic [CMD_W-1:0] CMD_INS_WRITE  = 4'd5;
	localparam logic [CMD_W-1:0] CMD_REM_PRIO   = 4'd6;
	localparam logic [CMD_W-1:0] CMD_REM_READ   = 4'd7;
	localparam logic [CMD_W-1:0] CMD_REM_HEAD   = 4'd8;
	localparam logic [CMD_W-1:0] CMD_WALK_READ  = 4'd9;
	localparam logic [CMD_W-1:0] CMD_WALK_CHECK = 4'd10;
	localparam logic [CMD_W-1:0] CMD_REM_FINISH = 4'd11;
	localparam logic [CMD_W-1:0] CMD_TOP_FIND   = 4'd12;
	localparam logic [CMD_W-1:0] CMD_OUT_LOAD   = 4'd13;

	// Datapath status seen by the controller
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            queued;
		logic            head_hit;
		logic            head_valid;
		logic            walk_end;
		logic            link_match;
		logic            out_free;
	} dp_status_t;

	typedef logic [ROW_W-1:0] row_t;

	// Index of the lowest set bit of a row map; zero when empty
	function automatic logic [ROW_SHIFT-1:0] lowest_in_row(input row_t v);
		logic [ROW_SHIFT-1:0] r;
		r = '0;
		for (int i = ROW_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = ROW_SHIFT'(i);
			end
		end
		return r;
	endfunction

	// Index of the lowest set bit of the group map; zero when empty
	function automatic logic [ROW_IDX_W-1:0] lowest_row(input logic [NUM_ROWS-1:0] v);
		logic [ROW_IDX_W-1:0] r;
		r = '0;
		for (int i = NUM_ROWS - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = ROW_IDX_W'(i);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: design/bprq_req_if.sv
// Request channel: valid/ready handshake with op, task and priority payload.
`default_nettype none

interface bprq_req_if;
	import bprq_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [OP_W-1:0]       op;
	logic [TASK_ID_W-1:0]  task_id;
	logic [PRIO_REQ_W-1:0] priority_req;

	modport source (output valid, output op, output task_id, output priority_req,
		input ready);
	modport sink (input valid, input op, input task_id, input priority_req,
		output ready);
endinterface

`default_nettype wire

FILE: design/bprq_rsp_if.sv
// Result channel: valid/ready handshake with status and top-of-queue payload.
`default_nettype none

interface bprq_rsp_if;
	import bprq_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [STATUS_W-1:0]   status;
	logic                  any_ready;
	logic [PRIO_REQ_W-1:0] top_priority;
	logic [TASK_ID_W-1:0]  top_task;

	modport source (output valid, output status, output any_ready, output top_priority,
		output top_task, input ready);
	modport sink (input valid, input status, input any_ready, input top_priority,
		input top_task, output ready);
endinterface

`default_nettype wire

FILE: design/bprq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bprq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

`default_nettype wire

FILE: design/bprq_ctrl.sv
// Sequencing state machine for insert, remove, list walk and result load.
`default_nettype none

module bprq_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_ready,
	input  bprq_pkg::dp_status_t     dp_status,
	output logic [bprq_pkg::CMD_W-1:0] cmd
);
	import bprq_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_CHECK    = 4'd1;
	localparam logic [3:0] S_INS_WR   = 4'd2;
	localparam logic [3:0] S_REM_ADDR = 4'd3;
	localparam logic [3:0] S_REM_HEAD = 4'd4;
	localparam logic [3:0] S_WALK_RD  = 4'd5;
	localparam logic [3:0] S_WALK_CHK = 4'd6;
	localparam logic [3:0] S_REM_FIN  = 4'd7;
	localparam logic [3:0] S_TOP      = 4'd8;
	localparam logic [3:0] S_OUT      = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = CMD_NOP;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd       = CMD_CAPTURE;
					state_nxt = S_CHECK;
				end
			end
			S_CHECK: begin
				if (dp_status.op == OP_INSERT) begin
					if (dp_status.queued) begin
						cmd       = CMD_REJECT_DUP;
						state_nxt = S_TOP;
					end else begin
						cmd       = CMD_INS_READ;
						state_nxt = S_INS_WR;
					end
				end else begin
					if (!dp_status.queued) begin
						cmd       = CMD_REJECT_ABS;
						state_nxt = S_TOP;
					end else begin
						cmd       = CMD_REM_PRIO;
						state_nxt = S_REM_ADDR;
					end
				end
			end
			S_INS_WR: begin
				cmd       = CMD_INS_WRITE;
				state_nxt = S_TOP;
			end
			S_REM_ADDR: begin
				cmd       = CMD_REM_READ;
				state_nxt = S_REM_HEAD;
			end
			S_REM_HEAD: begin
				cmd = CMD_REM_HEAD;
				if (!dp_status.head_hit && dp_status.head_valid) begin
					state_nxt = S_WALK_RD;
				end else begin
					state_nxt = S_REM_FIN;
				end
			end
			S_WALK_RD: begin
				if (dp_status.walk_end) begin
					state_nxt = S_REM_FIN;
				end else begin
					cmd       = CMD_WALK_READ;
					state_nxt = S_WALK_CHK;
				end
			end
			S_WALK_CHK: begin
				cmd = CMD_WALK_CHECK;
				if (dp_status.link_match) begin
					state_nxt = S_REM_FIN;
				end else begin
					state_nxt = S_WALK_RD;
				end
			end
			S_REM_FIN: begin
				cmd       = CMD_REM_FINISH;
				state_nxt = S_TOP;
			end
			S_TOP: begin
				cmd       = CMD_TOP_FIND;
				state_nxt = S_OUT;
			end
			S_OUT: begin
				if (dp_status.out_free) begin
					cmd       = CMD_OUT_LOAD;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign req_ready = (state_q == S_IDLE);
endmodule

`default_nettype wire

FILE: design/bprq_dpath.sv
// Queue state, bitmaps, list RAMs and result register driven by controller commands.
`default_nettype none

module bprq_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [bprq_pkg::CMD_W-1:0]    cmd,
	output bprq_pkg::dp_status_t          dp_status,
	input  logic [bprq_pkg::OP_W-1:0]     in_op,
	input  logic [bprq_pkg::TASK_ID_W-1:0] in_task_id,
	input  logic [bprq_pkg::PRIO_REQ_W-1:0] in_priority_req,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bprq_pkg::STATUS_W-1:0] out_status,
	output logic                          out_any_ready,
	output logic [bprq_pkg::PRIO_REQ_W-1:0] out_top_priority,
	output logic [bprq_pkg::TASK_ID_W-1:0] out_top_task
);
	import bprq_pkg::*;

	// Control state
	logic [NUM_PRIORITIES-1:0] head_valid_q;
	logic [NUM_TASKS-1:0]      link_valid_q;
	logic [NUM_TASKS-1:0]      queued_q;
	row_t                      row_bits_q [NUM_ROWS];
	logic [NUM_ROWS-1:0]       group_q;
	logic                      out_valid_q;

	// Working registers
	logic [OP_W-1:0]     op_q;
	logic [TASK_W-1:0]   t_q;
	logic [PRIO_W-1:0]   p_q;
	logic [STATUS_W-1:0] status_q;
	logic [TASK_W-1:0]   cur_q;
	logic [TASK_W-1:0]   nxt_t_q;
	logic                lv_t_q;
	logic [STEP_W-1:0]   steps_q;
	logic [PRIO_W-1:0]   top_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic                  out_any_q;
	logic [PRIO_REQ_W-1:0] out_prio_q;
	logic [TASK_ID_W-1:0]  out_task_q;

	// RAM ports
	logic              head_we, head_re, link_we, link_re, held_we, held_re;
	logic [PRIO_W-1:0] head_waddr, head_raddr;
	logic [TASK_W-1:0] head_wdata, head_rdata;
	logic [TASK_W-1:0] link_waddr, link_raddr, link_wdata, link_rdata;
	logic [PRIO_W-1:0] held_rdata;

	// Derived values
	logic [PRIO_W-1:0]    prio_sat;
	logic [ROW_IDX_W-1:0] row_sel;
	logic [ROW_SHIFT-1:0] row_bit;
	row_t                 row_cleared;
	logic [ROW_IDX_W-1:0] top_row;
	logic [PRIO_W-1:0]    top_w;
	logic                 head_hit;
	logic                 any_w;

	assign prio_sat = (int'(in_priority_req) >= NUM_PRIORITIES)
		? PRIO_W'(NUM_PRIORITIES - 1) : PRIO_W'(in_priority_req);

	assign row_sel     = p_q[PRIO_W-1:ROW_SHIFT];
	assign row_bit     = p_q[ROW_SHIFT-1:0] & ROW_MASK;
	assign row_cleared = row_bits_q[row_sel] & ~(row_t'(1) << row_bit);

	assign top_row = lowest_row(group_q);
	assign top_w   = {top_row, lowest_in_row(row_bits_q[top_row])};
	assign any_w   = |group_q;

	assign head_hit = head_valid_q[p_q] && (head_rdata == t_q);

	// RAM address and write steering
	always_comb begin
		head_we    = 1'b0;
		head_waddr = p_q;
		head_wdata = t_q;
		head_re    = 1'b0;
		head_raddr = p_q;
		link_we    = 1'b0;
		link_waddr = t_q;
		link_wdata = head_rdata;
		link_re    = 1'b0;
		link_raddr = t_q;
		held_we    = 1'b0;
		held_re    = 1'b0;
		case (cmd)
			CMD_INS_READ: begin
				head_re = 1'b1;
			end
			CMD_INS_WRITE: begin
				head_we = 1'b1;
				link_we = 1'b1;
				held_we = 1'b1;
			end
			CMD_REM_PRIO: begin
				held_re = 1'b1;
			end
			CMD_REM_READ: begin
				head_re    = 1'b1;
				head_raddr = held_rdata;
				link_re    = 1'b1;
			end
			CMD_REM_HEAD: begin
				head_we    = head_hit;
				head_wdata = link_rdata;
			end
			CMD_WALK_READ: begin
				link_re    = 1'b1;
				link_raddr = cur_q;
			end
			CMD_WALK_CHECK: begin
				link_we    = (link_rdata == t_q);
				link_waddr = cur_q;
				link_wdata = nxt_t_q;
			end
			CMD_TOP_FIND: begin
				head_re    = 1'b1;
				head_raddr = top_w;
			end
			default: begin
			end
		endcase
	end

	bprq_ram #(.WIDTH(TASK_W), .DEPTH(NUM_PRIORITIES)) u_head_ram (
		.clk   (clk),
		.we    (head_we),
		.waddr (head_waddr),
		.wdata (head_wdata),
		.re    (head_re),
		.raddr (head_raddr),
		.rdata (head_rdata)
	);

	bprq_ram #(.WIDTH(TASK_W), .DEPTH(NUM_TASKS)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (link_re),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	bprq_ram #(.WIDTH(PRIO_W), .DEPTH(NUM_TASKS)) u_held_ram (
		.clk   (clk),
		.we    (held_we),
		.waddr (t_q),
		.wdata (p_q),
		.re    (held_re),
		.raddr (t_q),
		.rdata (held_rdata)
	);

	// Bitmaps, valid bits and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= '0;
			link_valid_q <= '0;
			queued_q     <= '0;
			row_bits_q   <= '{default: '0};
			group_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd == CMD_OUT_LOAD) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd)
				CMD_INS_WRITE: begin
					link_valid_q[t_q]   <= head_valid_q[p_q];
					head_valid_q[p_q]   <= 1'b1;
					queued_q[t_q]       <= 1'b1;
					row_bits_q[row_sel] <= row_bits_q[row_sel] | (row_t'(1) << row_bit);
					group_q[row_sel]    <= 1'b1;
				end
				CMD_REM_HEAD: begin
					if (head_hit) begin
						head_valid_q[p_q] <= link_valid_q[t_q];
					end
				end
				CMD_WALK_CHECK: begin
					if (link_rdata == t_q) begin
						link_valid_q[cur_q] <= lv_t_q;
					end
				end
				CMD_REM_FINISH: begin
					link_valid_q[t_q] <= 1'b0;
					queued_q[t_q]     <= 1'b0;
					if (!head_valid_q[p_q]) begin
						row_bits_q[row_sel] <= row_cleared;
						if (row_cleared == '0) begin
							group_q[row_sel] <= 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Working and result payload
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_CAPTURE: begin
				op_q     <= in_op;
				t_q      <= in_task_id[TASK_W-1:0];
				p_q      <= prio_sat;
				status_q <= STATUS_DONE;
			end
			CMD_REJECT_DUP: begin
				status_q <= STATUS_DUP;
			end
			CMD_REJECT_ABS: begin
				status_q <= STATUS_ABSENT;
			end
			CMD_REM_READ: begin
				p_q <= held_rdata;
			end
			CMD_REM_HEAD: begin
				nxt_t_q <= link_rdata;
				lv_t_q  <= link_valid_q[t_q];
				cur_q   <= head_rdata;
				steps_q <= '0;
			end
			CMD_WALK_READ: begin
				steps_q <= steps_q + STEP_W'(1);
			end
			CMD_WALK_CHECK: begin
				cur_q <= link_rdata;
			end
			CMD_TOP_FIND: begin
				top_q <= top_w;
			end
			CMD_OUT_LOAD: begin
				out_status_q <= status_q;
				out_any_q    <= any_w;
				out_prio_q   <= any_w ? PRIO_REQ_W'(top_q) : '0;
				out_task_q   <= (any_w && head_valid_q[top_q]) ? TASK_ID_W'(head_rdata) : '0;
			end
			default: begin
			end
		endcase
	end

	assign dp_status.op         = op_q;
	assign dp_status.queued     = queued_q[t_q];
	assign dp_status.head_hit   = head_hit;
	assign dp_status.head_valid = head_valid_q[p_q];
	assign dp_status.walk_end   = (int'(steps_q) == NUM_TASKS) || !link_valid_q[cur_q];
	assign dp_status.link_match = (link_rdata == t_q);
	assign dp_status.out_free   = !out_valid_q || out_ready;

	assign out_valid        = out_valid_q;
	assign out_status       = out_status_q;
	assign out_any_ready    = out_any_q;
	assign out_top_priority = out_prio_q;
	assign out_top_task     = out_task_q;
endmodule

`default_nettype wire

FILE: design/bitmap_priority_ready_queue_top.sv
// Top level of the bitmap priority ready queue: controller, datapath and channels.
`default_nettype none

// Ready queue for a priority scheduler. Each request transaction either inserts a
// task at a priority (pushed onto the head of that priority's list) or removes a
// task from the list of the priority it was queued at. Every request yields exactly
// one result transaction carrying a status (done, already queued, not queued), a flag
// that some task is ready, the highest ready priority (lowest number) and the task at
// the head of that list; the last three read zero when nothing is ready. Priorities
// above the top saturate to the lowest priority; task ids wrap to the task count.
// One request is processed at a time. A removal walks the list link by link when the
// task is not at the head of its list; the walk is set by the single read port of the
// link RAM: each step reads one next-link and compares it before the following read
// can be issued.
// A finished result sits in an output register; the block takes the next request
// while it waits and stalls only before loading a new result into a still-full
// register. List heads, links and stored priorities live in RAMs; head, link and
// queued valid bits are flip-flops cleared by reset, so no clearing pass is needed.

module bitmap_priority_ready_queue_top (
	input  logic       clk,
	input  logic       arst_n,
	bprq_req_if.sink   req,
	bprq_rsp_if.source rsp
);
	import bprq_pkg::*;

	logic [CMD_W-1:0] cmd;
	dp_status_t       dp_status;

	// Sequencer: accepts a request when idle, then steps the datapath
	bprq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.dp_status (dp_status),
		.cmd       (cmd)
	);

	// Queue state, list RAMs and the result register
	bprq_dpath u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.dp_status        (dp_status),
		.in_op            (req.op),
		.in_task_id       (req.task_id),
		.in_priority_req  (req.priority_req),
		.out_valid        (rsp.valid),
		.out_ready        (rsp.ready),
		.out_status       (rsp.status),
		.out_any_ready    (rsp.any_ready),
		.out_top_priority (rsp.top_priority),
		.out_top_task     (rsp.top_task)
	);
endmodule

`default_nettype wire
